[design/complex_matrix_vector_mac_macros.svh]
// Assertion macros shared by the complex matrix-vector MAC modules.
`ifndef COMPLEX_MATRIX_VECTOR_MAC_MACROS_SVH
`define COMPLEX_MATRIX_VECTOR_MAC_MACROS_SVH

`ifndef SYNTHESIS
`define CMVM_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cmvm check failed");
`define CMVM_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cmvm check failed");
`else
`define CMVM_ASSERT_IMPL(name, clk, rst_n, pre, post)
`define CMVM_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

[design/cmvm_pkg.sv]
// Shared constants, types and helper functions of the complex matrix-vector MAC.
package cmvm_pkg;

    localparam int MAX_ORDER     = 64;
    localparam int OPERAND_BITS  = 16;
    localparam int ACC_BITS      = 48;
    localparam int ROW_BITS      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int DIM_BITS      = 7;
    localparam int PROD_BITS     = 2 * OPERAND_BITS;
    localparam int SUM_BITS      = ACC_BITS + 2;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int S_TDATA_BITS  = ((4 * OPERAND_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS  = ((ROW_BITS + 2 * ACC_BITS + 7) / 8) * 8;

    typedef logic signed [OPERAND_BITS-1:0] operand_t;
    typedef logic signed [PROD_BITS-1:0]    prod_t;
    typedef logic signed [ACC_BITS-1:0]     acc_t;
    typedef logic signed [SUM_BITS-1:0]     sum_t;
    typedef logic [ROW_BITS-1:0]            row_t;
    typedef logic [ROW_BITS:0]              order_t;
    typedef logic [DIM_BITS-1:0]            dim_t;

    localparam dim_t DIM_RESET = DIM_BITS'(MAX_ORDER);

    typedef enum logic [APB_ADDR_BITS-3:0] {
        REG_DIM_IN_USE = '0
    } reg_idx_t;

    typedef struct packed {
        row_t row;
        logic last;
    } step_t;

    typedef struct packed {
        logic en;
        row_t addr;
        acc_t re;
        acc_t im;
    } acc_wr_t;

    typedef struct packed {
        acc_t re;
        acc_t im;
    } acc_rd_t;

    function automatic order_t clamp_dim(dim_t d);
        order_t res;
        if (d == '0) begin
            res = order_t'(1);
        end else if (int'(d) > MAX_ORDER) begin
            res = order_t'(MAX_ORDER);
        end else begin
            res = order_t'(d);
        end
        return res;
    endfunction

    function automatic acc_t sat_acc(sum_t s);
        logic [SUM_BITS-ACC_BITS:0] hi;
        acc_t res;
        hi = s[SUM_BITS-1:ACC_BITS-1];
        if ((&hi) || !(|hi)) begin
            res = s[ACC_BITS-1:0];
        end else if (s[SUM_BITS-1]) begin
            res = {1'b1, {(ACC_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

[design/complex_matrix_vector_mac.sv]
// Top level of the streaming complex matrix-vector multiply-accumulate block.
//
//  channel   dir   handshake         payload
//  s_*       in    tvalid / tready   tdata: mat_re, mat_im, vec_re, vec_im; tuser: clear_acc
//  m_*       out   tvalid / tready   tdata: row_index, acc_re, acc_im; tlast: pass_done
//  apb       in    psel / penable    dim_in_use at byte address 0
//
//  One beat per cycle sustained while m_tready is high; m_tvalid rises once the beat has passed
//  the operand register, product register and accumulate-and-saturate result register.
//  Accumulators read as zero after reset through per-row valid bits; no clearing pass.
//  Three beats fit in flight; with m_tready low s_tready drops once all stages are full.
module complex_matrix_vector_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] mat_re, [31:16] mat_im, [47:32] vec_re, [63:48] vec_im
    input  logic [cmvm_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // [0] clear_acc
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [5:0] row_index, [53:6] acc_re, [101:54] acc_im, zero fill above
    output logic [cmvm_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cmvm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cmvm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cmvm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    localparam int OB = cmvm_pkg::OPERAND_BITS;

    cmvm_pkg::dim_t     dim;
    cmvm_pkg::step_t    cur;
    cmvm_pkg::acc_rd_t  rd;
    cmvm_pkg::acc_wr_t  wr;
    cmvm_pkg::row_t     out_row;
    cmvm_pkg::acc_t     out_re, out_im;
    logic               accept;

    assign accept = s_tvalid && s_tready;

    cmvm_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dim     (dim)
    );

    cmvm_index_ctrl u_index (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (accept),
        .dim     (dim),
        .cur     (cur)
    );

    cmvm_acc_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (cur.row),
        .wr      (wr),
        .rd      (rd)
    );

    cmvm_mac_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .mat_re    (s_tdata[OB-1:0]),
        .mat_im    (s_tdata[2*OB-1:OB]),
        .vec_re    (s_tdata[3*OB-1:2*OB]),
        .vec_im    (s_tdata[4*OB-1:3*OB]),
        .clear_acc (s_tuser),
        .cur       (cur),
        .rd        (rd),
        .wr        (wr),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_row     (out_row),
        .m_re      (out_re),
        .m_im      (out_im),
        .m_last    (m_tlast)
    );

    assign m_tdata = cmvm_pkg::M_TDATA_BITS'({out_im, out_re, out_row});

endmodule

[design/cmvm_apb_regs.sv]
// APB register file holding the matrix order in use.
module cmvm_apb_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cmvm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cmvm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cmvm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output cmvm_pkg::dim_t                      dim
);

    cmvm_pkg::dim_t     dim_reg;
    cmvm_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = cmvm_pkg::reg_idx_t'(paddr[cmvm_pkg::APB_ADDR_BITS-1:2]);
    assign dim     = dim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= cmvm_pkg::DIM_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                cmvm_pkg::REG_DIM_IN_USE: begin
                    dim_reg <= pwdata[cmvm_pkg::DIM_BITS-1:0];
                end
                default: begin
                    dim_reg <= dim_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cmvm_pkg::REG_DIM_IN_USE: begin
                prdata = cmvm_pkg::APB_DATA_BITS'(dim_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

[design/cmvm_index_ctrl.sv]
// Row and column counters that walk the matrix in column-major order.
module cmvm_index_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  cmvm_pkg::dim_t   dim,
    output cmvm_pkg::step_t  cur
);

    cmvm_pkg::row_t   row_reg, row_next;
    cmvm_pkg::row_t   col_reg, col_next;
    cmvm_pkg::order_t dim_eff, last_idx;
    logic             row_last, col_last;

    always_comb begin
        dim_eff  = cmvm_pkg::clamp_dim(dim);
        last_idx = dim_eff - cmvm_pkg::order_t'(1);
        row_last = {1'b0, row_reg} >= last_idx;
        col_last = {1'b0, col_reg} >= last_idx;
        cur.row  = row_reg;
        cur.last = row_last && col_last;
        row_next = row_reg + cmvm_pkg::row_t'(1);
        col_next = col_reg;
        if (row_last) begin
            row_next = '0;
            col_next = col_last ? '0 : col_reg + cmvm_pkg::row_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (advance) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

[design/cmvm_acc_ram.sv]
// Per-row complex accumulator memory with valid bits and a registered read port.
`include "complex_matrix_vector_mac_macros.svh"

module cmvm_acc_ram (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  cmvm_pkg::row_t    rd_addr,
    input  cmvm_pkg::acc_wr_t wr,
    output cmvm_pkg::acc_rd_t rd
);

    cmvm_pkg::acc_t                 mem_re [cmvm_pkg::MAX_ORDER];
    cmvm_pkg::acc_t                 mem_im [cmvm_pkg::MAX_ORDER];
    logic [cmvm_pkg::MAX_ORDER-1:0] vld_reg;
    logic                           rd_vld_reg;
    cmvm_pkg::acc_t                 rd_re_reg, rd_im_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_re[wr.addr] <= wr.re;
            mem_im[wr.addr] <= wr.im;
        end
        if (rd_en) begin
            rd_re_reg <= mem_re[rd_addr];
            rd_im_reg <= mem_im[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // unwritten rows read as zero
    assign rd.re = rd_vld_reg ? rd_re_reg : '0;
    assign rd.im = rd_vld_reg ? rd_im_reg : '0;

    `CMVM_ASSERT_NEXT(a_write_sets_valid, aclk, aresetn, wr.en, vld_reg[$past(wr.addr)])

endmodule

[design/cmvm_mac_pipe.sv]
// Three-stage complex multiply-accumulate pipeline with accumulator forwarding.
`include "complex_matrix_vector_mac_macros.svh"

module cmvm_mac_pipe (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cmvm_pkg::operand_t mat_re,
    input  cmvm_pkg::operand_t mat_im,
    input  cmvm_pkg::operand_t vec_re,
    input  cmvm_pkg::operand_t vec_im,
    input  logic              clear_acc,
    input  cmvm_pkg::step_t   cur,
    input  cmvm_pkg::acc_rd_t rd,
    output cmvm_pkg::acc_wr_t wr,
    output logic              m_valid,
    input  logic              m_ready,
    output cmvm_pkg::row_t    m_row,
    output cmvm_pkg::acc_t    m_re,
    output cmvm_pkg::acc_t    m_im,
    output logic              m_last
);

    // stage 1: operands
    logic               v1_reg, clr1_reg, last1_reg;
    cmvm_pkg::row_t     row1_reg;
    cmvm_pkg::operand_t mr1_reg, mi1_reg, vr1_reg, vi1_reg;
    // stage 2: products and base accumulator
    logic               v2_reg, last2_reg;
    cmvm_pkg::row_t     row2_reg;
    cmvm_pkg::prod_t    p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    cmvm_pkg::acc_t     base_re_reg, base_im_reg, base_re_next, base_im_next;
    // stage 3: result, also the most recent accumulator write
    logic               v3_reg, last3_reg, lw_vld_reg;
    cmvm_pkg::row_t     row3_reg;
    cmvm_pkg::acc_t     re3_reg, im3_reg;

    logic               s3_ready, s2_ready, adv1, adv2, accept;
    cmvm_pkg::sum_t     sum_re, sum_im;
    cmvm_pkg::acc_t     sat_re, sat_im;

    assign s3_ready = !v3_reg || m_ready;
    assign s2_ready = !v2_reg || s3_ready;
    assign s_ready  = !v1_reg || s2_ready;
    assign accept   = s_valid && s_ready;
    assign adv1     = v1_reg && s2_ready;
    assign adv2     = v2_reg && s3_ready;

    always_comb begin
        sum_re = cmvm_pkg::sum_t'(base_re_reg) + cmvm_pkg::sum_t'(p_rr_reg)
               - cmvm_pkg::sum_t'(p_ii_reg);
        sum_im = cmvm_pkg::sum_t'(base_im_reg) + cmvm_pkg::sum_t'(p_ri_reg)
               + cmvm_pkg::sum_t'(p_ir_reg);
        sat_re = cmvm_pkg::sat_acc(sum_re);
        sat_im = cmvm_pkg::sat_acc(sum_im);
    end

    // pick the newest value of the row: zero on clear_acc, else the update in flight, the last write, or memory
    always_comb begin
        if (clr1_reg) begin
            base_re_next = '0;
            base_im_next = '0;
        end else if (v2_reg && (row2_reg == row1_reg)) begin
            base_re_next = sat_re;
            base_im_next = sat_im;
        end else if (lw_vld_reg && (row3_reg == row1_reg)) begin
            base_re_next = re3_reg;
            base_im_next = im3_reg;
        end else begin
            base_re_next = rd.re;
            base_im_next = rd.im;
        end
    end

    assign wr.en   = adv2;
    assign wr.addr = row2_reg;
    assign wr.re   = sat_re;
    assign wr.im   = sat_im;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            lw_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (s2_ready) begin
                v2_reg <= v1_reg;
            end
            if (s3_ready) begin
                v3_reg <= v2_reg;
            end
            if (adv2) begin
                lw_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mr1_reg   <= mat_re;
            mi1_reg   <= mat_im;
            vr1_reg   <= vec_re;
            vi1_reg   <= vec_im;
            clr1_reg  <= clear_acc;
            row1_reg  <= cur.row;
            last1_reg <= cur.last;
        end
        if (adv1) begin
            p_rr_reg    <= cmvm_pkg::prod_t'(mr1_reg) * cmvm_pkg::prod_t'(vr1_reg);
            p_ii_reg    <= cmvm_pkg::prod_t'(mi1_reg) * cmvm_pkg::prod_t'(vi1_reg);
            p_ri_reg    <= cmvm_pkg::prod_t'(mr1_reg) * cmvm_pkg::prod_t'(vi1_reg);
            p_ir_reg    <= cmvm_pkg::prod_t'(mi1_reg) * cmvm_pkg::prod_t'(vr1_reg);
            base_re_reg <= base_re_next;
            base_im_reg <= base_im_next;
            row2_reg    <= row1_reg;
            last2_reg   <= last1_reg;
        end
        if (adv2) begin
            re3_reg   <= sat_re;
            im3_reg   <= sat_im;
            row3_reg  <= row2_reg;
            last3_reg <= last2_reg;
        end
    end

    assign m_valid = v3_reg;
    assign m_row   = row3_reg;
    assign m_re    = re3_reg;
    assign m_im    = im3_reg;
    assign m_last  = last3_reg;

    `CMVM_ASSERT_NEXT(a_adv2_fills_out, aclk, aresetn, adv2, v3_reg && (row3_reg == $past(row2_reg)))
    `CMVM_ASSERT_NEXT(a_s1_holds, aclk, aresetn, v1_reg && !s2_ready, v1_reg && $stable(row1_reg))
    `CMVM_ASSERT_IMPL(a_write_in_order, aclk, aresetn, adv2 && v3_reg, m_ready)

endmodule
